### hw/rtl/sammon_stress_evaluator_defines.svh
// assertion macros for the sammon stress evaluator
`ifndef SAMMON_STRESS_EVALUATOR_DEFINES_SVH
`define SAMMON_STRESS_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SSE_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define SSE_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define SSE_ASSERT_IMP(label, clk, rst_n, a, b)
`define SSE_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

### hw/rtl/sse_pkg.sv
// shared constants and types for the sammon stress evaluator
`default_nettype none
package sse_pkg;
	localparam int MaxPoints = 256;
	localparam int MaxDims = 64;
	localparam int PtW = $clog2(MaxPoints);
	localparam int DimW = $clog2(MaxDims);
	localparam int AddrW = PtW + DimW;
	localparam int CntW = PtW + 1;
	localparam int DcntW = DimW + 1;
	localparam int TotW = 48;
	localparam logic [47:0] TotalMax = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0] TinySq = 64'd42950;
	localparam logic CfgPointCount = 1'b0;
	localparam logic CfgDimCount = 1'b1;

	typedef struct packed {
		logic [PtW-1:0]  point_index;
		logic [DimW-1:0] coord_index;
		logic signed [15:0] coord_value;
		logic [15:0] proj_first;
		logic [15:0] proj_second;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] stress;
		logic saturated;
	} out_item_t;

	typedef struct packed {
		logic [0:0]  index;
		logic [15:0] data;
	} cfg_item_t;
endpackage
`default_nettype wire

### hw/rtl/sse_stream_if.sv
// valid/ready channel interfaces
`default_nettype none
interface sse_in_if;
	logic valid;
	logic ready;
	sse_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sse_out_if;
	logic valid;
	logic ready;
	sse_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sse_cfg_if;
	logic valid;
	logic ready;
	sse_pkg::cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/sse_root.sv
// iterative floor square root of a 64-bit value, one result bit per cycle
`default_nettype none
module sse_root (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] x,
	output logic             done,
	output logic [31:0]      root
);
	logic [63:0] rem_q;
	logic [31:0] r_q;
	logic [5:0]  step_q;
	logic        busy_q;
	logic [65:0] trial;
	logic [63:0] x_q;
	logic [65:0] part;

	always_comb begin
		trial = {32'd0, r_q, 2'b01};
	end

	assign part = {rem_q, x_q[63:62]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			rem_q <= '0;
			r_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[61:0], 2'b00};
			if (part >= trial) begin
				rem_q <= 64'(part - trial);
				r_q <= {r_q[30:0], 1'b1};
			end else begin
				rem_q <= part[63:0];
				r_q <= {r_q[30:0], 1'b0};
			end
		end
	end

	assign root = r_q;
endmodule
`default_nettype wire

### hw/rtl/sammon_stress_evaluator.sv
// top level: point stores, pair walk sequencer and stress division
//
// channel  dir  payload
// in       in   point_index coord_index coord_value proj_first proj_second last
// out      out  stress saturated
// cfg      in   index data
//
// loading takes one item per cycle while idle into the coordinate and projection memories
// a last item starts the pair walk; each pair runs the squared sum, two square roots
// and a mismatch divide, and the stress divide follows the last pair;
// the serial root and divide units set the pace
// reset clears only control state and the totals; the memories need no clearing
// the input stalls for the whole walk and until the result is taken
`include "sammon_stress_evaluator_defines.svh"
`default_nettype none
module sammon_stress_evaluator (
	input  wire logic clk,
	input  wire logic arst_n,
	sse_in_if.sink    in_ch,
	sse_out_if.source out_ch,
	sse_cfg_if.sink   cfg
);
	localparam logic [3:0] StIdle = 4'd0, StRdP = 4'd1, StSum = 4'd2, StRoot1 = 4'd3,
		StWait1 = 4'd4, StRoot2 = 4'd5, StWait2 = 4'd6, StDiv = 4'd7, StAcc = 4'd8,
		StNext = 4'd9, StFin = 4'd10, StSdiv = 4'd11, StOut = 4'd12;

	logic [3:0] st_q;
	logic [sse_pkg::CntW-1:0] npts_q;
	logic [sse_pkg::DcntW-1:0] ndims_q;

	logic [15:0] coord_mem [sse_pkg::MaxPoints*sse_pkg::MaxDims];
	logic [31:0] proj_mem [sse_pkg::MaxPoints];

	logic in_fire;
	assign in_ch.ready = (st_q == StIdle);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			npts_q <= sse_pkg::CntW'(sse_pkg::MaxPoints);
			ndims_q <= sse_pkg::DcntW'(sse_pkg::MaxDims);
		end else if (cfg.valid) begin
			case (cfg.data.index)
				sse_pkg::CfgPointCount: npts_q <= (cfg.data.data[8:0] >
					9'(sse_pkg::MaxPoints)) ? sse_pkg::CntW'(sse_pkg::MaxPoints) :
					sse_pkg::CntW'(cfg.data.data[8:0]);
				sse_pkg::CfgDimCount: ndims_q <= (cfg.data.data[6:0] >
					7'(sse_pkg::MaxDims)) ? sse_pkg::DcntW'(sse_pkg::MaxDims) :
					sse_pkg::DcntW'(cfg.data.data[6:0]);
				default: ;
			endcase
		end
	end

	// walk indices
	logic [sse_pkg::CntW-1:0] i_q, j_q;
	logic [sse_pkg::DcntW:0] k_q;
	logic [sse_pkg::AddrW-1:0] rd_addr;
	logic [15:0] rd_data_q;
	logic [31:0] pa_q, pb_q, prd_q;
	logic [sse_pkg::PtW-1:0] prd_addr;
	logic rd_j;

	// k_q even reads point i, odd reads point j
	assign rd_j = k_q[0];
	assign rd_addr = {rd_j ? j_q[sse_pkg::PtW-1:0] : i_q[sse_pkg::PtW-1:0],
		k_q[sse_pkg::DimW:1]};
	assign prd_addr = rd_j ? j_q[sse_pkg::PtW-1:0] : i_q[sse_pkg::PtW-1:0];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			coord_mem[{in_ch.data.point_index, in_ch.data.coord_index}] <=
				in_ch.data.coord_value;
			if (in_ch.data.coord_index == '0)
				proj_mem[in_ch.data.point_index] <= {in_ch.data.proj_second,
					in_ch.data.proj_first};
		end
		rd_data_q <= coord_mem[rd_addr];
		prd_q <= proj_mem[prd_addr];
	end

	// squared sum pipeline: pair of reads then difference
	logic [15:0] ci_q;
	logic [31:0] sq_s1;
	logic sq_v_s1, got_v_q, got_j_q;
	logic [37:0] ssum_q;
	logic signed [16:0] diff;
	logic [16:0] adiff;
	assign diff = 17'(signed'(ci_q)) - 17'(signed'(rd_data_q));
	assign adiff = diff[16] ? 17'(-diff) : diff;

	// root unit shared by both distances
	logic root_start, root_done;
	logic [63:0] root_x;
	logic [31:0] root_r;
	sse_root u_root (.clk, .arst_n, .start(root_start), .x(root_x),
		.done(root_done), .root(root_r));

	logic [31:0] t1_q, t2_q;
	logic [63:0] s2;
	logic [16:0] pd1, pd2;
	assign pd1 = (pa_q[15:0] > pb_q[15:0]) ? 17'(pa_q[15:0] - pb_q[15:0]) :
		17'(pb_q[15:0] - pa_q[15:0]);
	assign pd2 = (pa_q[31:16] > pb_q[31:16]) ? 17'(pa_q[31:16] - pb_q[31:16]) :
		17'(pb_q[31:16] - pa_q[31:16]);
	logic [33:0] pm1_q, pm2_q;
	assign s2 = 64'(pm1_q) + 64'(pm2_q);

	// shared restoring divider: num / den, one quotient bit per cycle
	logic [63:0] dnum_q, drem_q;
	logic [47:0] dden_q;
	logic [6:0] dcnt_q;
	logic [64:0] dtry;
	assign dtry = {drem_q, dnum_q[63]};

	logic [47:0] dist_tot_q, mis_tot_q;
	logic [48:0] dsum, msum;
	assign dsum = 49'(dist_tot_q) + 49'(t1_q);
	assign msum = 49'(mis_tot_q) + 49'(dnum_q[47:0]);

	logic [63:0] dq;
	assign dq = dnum_q;

	logic res_v_q;
	sse_pkg::out_item_t res_q;
	assign out_ch.valid = res_v_q;
	assign out_ch.data = res_q;

	logic [sse_pkg::DcntW:0] klim;
	assign klim = {ndims_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			res_v_q <= 1'b0;
			dist_tot_q <= '0;
			mis_tot_q <= '0;
			root_start <= 1'b0;
			sq_v_s1 <= 1'b0;
			got_v_q <= 1'b0;
		end else begin
			root_start <= 1'b0;
			sq_v_s1 <= 1'b0;
			if (out_ch.valid && out_ch.ready)
				res_v_q <= 1'b0;
			case (st_q)
				StIdle: begin
					if (in_fire && in_ch.data.last) begin
						dist_tot_q <= '0;
						mis_tot_q <= '0;
						i_q <= '0;
						j_q <= sse_pkg::CntW'(1);
						st_q <= (npts_q < sse_pkg::CntW'(2)) ? StFin : StRdP;
						k_q <= '0;
					end
				end
				StRdP: begin
					// read projection i then j
					k_q <= k_q + 1'b1;
					if (k_q == 1) pa_q <= prd_q;
					if (k_q == 2) begin
						pb_q <= prd_q;
						k_q <= '0;
						ssum_q <= '0;
						got_v_q <= 1'b0;
						st_q <= StSum;
					end
				end
				StSum: begin
					// issue reads i,j per dimension; the read data arrives in the following cycle
					got_v_q <= (k_q < klim);
					got_j_q <= rd_j;
					if (k_q < klim) k_q <= k_q + 1'b1;
					if (got_v_q && !got_j_q) ci_q <= rd_data_q;
					if (got_v_q && got_j_q) begin
						sq_s1 <= 32'(adiff) * 32'(adiff);
						sq_v_s1 <= 1'b1;
					end
					if (sq_v_s1) ssum_q <= ssum_q + 38'(sq_s1);
					if (k_q >= klim && !got_v_q && !sq_v_s1) begin
						st_q <= StRoot1;
						pm1_q <= 34'(pd1) * 34'(pd1);
						pm2_q <= 34'(pd2) * 34'(pd2);
					end
				end
				StRoot1: begin
					root_x <= (ssum_q == '0) ? sse_pkg::TinySq : {22'd0, ssum_q, 4'd0};
					root_start <= 1'b1;
					st_q <= StWait1;
				end
				StWait1: if (root_done) begin
					t1_q <= root_r;
					root_x <= s2;
					root_start <= 1'b1;
					st_q <= StWait2;
				end
				StWait2: if (root_done) begin
					t2_q <= root_r;
					st_q <= StRoot2;
				end
				StRoot2: begin
					// d*d numerator, t1 denominator
					dnum_q <= (t1_q > t2_q) ? 64'(t1_q - t2_q) * 64'(t1_q - t2_q) :
						64'(t2_q - t1_q) * 64'(t2_q - t1_q);
					dden_q <= 48'(t1_q);
					drem_q <= '0;
					dcnt_q <= 7'd64;
					st_q <= StDiv;
				end
				StDiv: begin
					if (dcnt_q != 0) begin
						dcnt_q <= dcnt_q - 1'b1;
						if (dtry >= 65'(dden_q)) begin
							drem_q <= 64'(dtry - 65'(dden_q));
							dnum_q <= {dnum_q[62:0], 1'b1};
						end else begin
							drem_q <= dtry[63:0];
							dnum_q <= {dnum_q[62:0], 1'b0};
						end
					end else st_q <= StAcc;
				end
				StAcc: begin
					dist_tot_q <= dsum[48] ? sse_pkg::TotalMax : dsum[47:0];
					mis_tot_q <= (msum[48] || dq[63:48] != 0) ? sse_pkg::TotalMax :
						msum[47:0];
					st_q <= StNext;
				end
				StNext: begin
					k_q <= '0;
					if (j_q + 1'b1 < npts_q) begin
						j_q <= j_q + 1'b1;
						st_q <= StRdP;
					end else if (i_q + 2'd2 < npts_q) begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + 2'd2;
						st_q <= StRdP;
					end else st_q <= StFin;
				end
				StFin: begin
					// stress = mis*2^24/dist, quotient >= 2^32 saturates; zero dist gives zero
					dnum_q <= {mis_tot_q[39:0], 24'd0};
					drem_q <= 64'(mis_tot_q[47:40]);
					dden_q <= dist_tot_q;
					dcnt_q <= 7'd64;
					st_q <= (dist_tot_q == '0) ? StOut : StSdiv;
					if (dist_tot_q == '0) begin
						res_q <= '0;
						res_v_q <= 1'b1;
					end
				end
				StSdiv: begin
					// the upper 8 bits come first as remainder seed
					if (dcnt_q != 0) begin
						dcnt_q <= dcnt_q - 1'b1;
						if (dtry >= 65'(dden_q)) begin
							drem_q <= 64'(dtry - 65'(dden_q));
							dnum_q <= {dnum_q[62:0], 1'b1};
						end else begin
							drem_q <= dtry[63:0];
							dnum_q <= {dnum_q[62:0], 1'b0};
						end
					end else begin
						res_q.saturated <= (dnum_q[63:32] != 0);
						res_q.stress <= (dnum_q[63:32] != 0) ? 32'hFFFF_FFFF : dnum_q[31:0];
						res_v_q <= 1'b1;
						st_q <= StOut;
					end
				end
				StOut: if (!res_v_q || out_ch.ready) st_q <= StIdle;
				default: st_q <= StIdle;
			endcase
		end
	end

	`SSE_ASSERT_IMP(a_no_load_busy, clk, arst_n, st_q != StIdle, !in_ch.ready)
	`SSE_ASSERT_NXT(a_fin_zero, clk, arst_n, st_q == StFin && dist_tot_q == '0,
		res_v_q && !res_q.saturated)
	`SSE_ASSERT_IMP(a_sat_max, clk, arst_n, res_v_q && res_q.saturated,
		res_q.stress == 32'hFFFF_FFFF)
endmodule
`default_nettype wire
